// ----- design/nre_pkg.sv -----
// Package for the nibble run-length expander: sizes, constants and shared types.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package nre_pkg;

  localparam int NRE_MAX_NIBBLES        = 4096;
  localparam int NRE_NIBBLES_PER_RESULT = 8;
  localparam int NRE_LIMIT_W            = 13;
  localparam int NRE_COUNT_W            = 9;
  localparam int NRE_NIB_W              = 4;
  localparam int NRE_NIBS_PER_WORD      = 8;
  localparam int NRE_WORD_W             = NRE_NIB_W * NRE_NIBS_PER_WORD;

  // Nibbles carried by one result; a word never holds more than eight.
  localparam logic [3:0] NRE_CHUNK =
    (NRE_NIBBLES_PER_RESULT > 8) ? 4'd8 : 4'(NRE_NIBBLES_PER_RESULT);

  // Sampled glyph limits saturate here.
  localparam logic [NRE_LIMIT_W-1:0] NRE_LIMIT_CAP =
    (NRE_MAX_NIBBLES > 8191) ? 13'h1FFF : 13'(NRE_MAX_NIBBLES);

  // Value of the unused nibble positions of a result word.
  localparam logic [NRE_NIB_W-1:0] NRE_PAD_NIB = 4'hF;

  typedef enum logic [0:0] {
    NRE_IDLE,
    NRE_EMIT
  } nre_state_t;

  typedef struct packed {
    logic [3:0]             take;
    logic [NRE_COUNT_W-1:0] rem_nxt;
    logic [NRE_LIMIT_W-1:0] done_nxt;
    logic                   last;
    logic                   limit_hit;
  } nre_chunk_t;

endpackage

// ----- design/nre_chunk_unit.sv -----
// Shared chunk unit: takes one result's worth of nibbles off the remaining count.
// Depends on nre_pkg.
`timescale 1ns / 1ps
module nre_chunk_unit
  import nre_pkg::*;
(
  input  logic [NRE_COUNT_W-1:0] rem,
  input  logic [NRE_LIMIT_W-1:0] done,
  input  logic [NRE_LIMIT_W-1:0] limit,
  output nre_chunk_t             chunk
);

  logic [3:0]             take;
  logic [NRE_LIMIT_W-1:0] done_sum;

  always_comb begin
    take = (rem < NRE_COUNT_W'(NRE_CHUNK)) ? rem[3:0] : NRE_CHUNK;
    done_sum = done + NRE_LIMIT_W'(take);
    chunk.take      = take;
    chunk.rem_nxt   = rem - NRE_COUNT_W'(take);
    chunk.done_nxt  = done_sum;
    chunk.last      = (rem == NRE_COUNT_W'(take));
    chunk.limit_hit = (done_sum >= limit);
  end

endmodule

// ----- design/nre_word_pack.sv -----
// Packs one result word: the first nibble on top, unused positions padded.
// Depends on nre_pkg.
`timescale 1ns / 1ps
module nre_word_pack
  import nre_pkg::*;
(
  input  logic [NRE_NIB_W-1:0]  hi_nib,
  input  logic [NRE_NIB_W-1:0]  lo_nib,
  input  logic [3:0]            take,
  output logic [NRE_WORD_W-1:0] word
);

  always_comb begin
    word = '0;
    for (int k = 0; k < NRE_NIBS_PER_WORD; k++) begin
      if (4'(k) < take) begin
        // Only a nibble pair has a distinct second nibble; runs load lo equal to hi.
        word[NRE_WORD_W-1-NRE_NIB_W*k -: NRE_NIB_W] = (k == 1) ? lo_nib : hi_nib;
      end else begin
        word[NRE_WORD_W-1-NRE_NIB_W*k -: NRE_NIB_W] = NRE_PAD_NIB;
      end
    end
  end

endmodule

// ----- design/nibble_rle_expander_core.sv -----
// Top level of the nibble run-length expander: byte decode, sequencer and result register.
// Depends on nre_pkg, nre_chunk_unit and nre_word_pack.
//
//   Channel  Ports                                             Direction
//   in       in_valid, in_stall, in_data_byte,                 into the block
//            in_first_of_glyph, in_nibble_limit
//   out      out_valid, out_stall, out_nibble_word,            out of the block
//            out_valid_count, out_run_end, out_limit_reached
//
// An item is taken, and each result of it then passes in turn through the shared chunk
// unit; a new item is not taken until the last result is loaded. Markers, zero counts
// and items past the limit give no result.
// Reset (rst_n low, synchronous) clears the glyph state and empties the result register.
// A stall on the result side holds the sequencer; in_stall is high while a byte expands.
`timescale 1ns / 1ps
module nibble_rle_expander_core
  import nre_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_first_of_glyph,
  input  logic [NRE_LIMIT_W-1:0] in_nibble_limit,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [NRE_WORD_W-1:0]  out_nibble_word,
  output logic [3:0]             out_valid_count,
  output logic                   out_run_end,
  output logic                   out_limit_reached
);

  nre_state_t             state_r, state_nxt;
  logic                   marker_r, marker_nxt;
  logic [NRE_NIB_W-1:0]   run_nib_r, run_nib_nxt;
  logic [NRE_LIMIT_W-1:0] done_r, done_nxt;
  logic [NRE_LIMIT_W-1:0] limit_r, limit_nxt;
  logic [NRE_COUNT_W-1:0] rem_r, rem_nxt;
  logic [NRE_NIB_W-1:0]   hi_r, hi_nxt;
  logic [NRE_NIB_W-1:0]   lo_r, lo_nxt;
  logic                   out_valid_r;
  logic [NRE_WORD_W-1:0]  out_word_r;
  logic [3:0]             out_count_r;
  logic                   out_end_r;
  logic                   out_limit_r;

  logic                   accept;
  logic                   load_en;
  logic                   start_emit;
  logic [NRE_LIMIT_W-1:0] lim_sat;
  logic [NRE_LIMIT_W-1:0] eff_limit;
  logic [NRE_LIMIT_W-1:0] eff_done;
  logic                   eff_marker;
  logic                   active;
  logic [NRE_LIMIT_W-1:0] room;
  logic [NRE_LIMIT_W-1:0] want;
  logic [NRE_LIMIT_W-1:0] total;
  logic [NRE_NIB_W-1:0]   byte_hi;
  logic [NRE_NIB_W-1:0]   byte_lo;
  nre_chunk_t             chunk;
  logic [NRE_WORD_W-1:0]  word;

  nre_chunk_unit u_chunk (
    .rem   (rem_r),
    .done  (done_r),
    .limit (limit_r),
    .chunk (chunk)
  );

  nre_word_pack u_pack (
    .hi_nib (hi_r),
    .lo_nib (lo_r),
    .take   (chunk.take),
    .word   (word)
  );

  // Sequencer outputs.
  always_comb begin
    in_stall = (state_r != NRE_IDLE);
    load_en  = (state_r == NRE_EMIT) && (!out_valid_r || !out_stall);
  end

  assign accept = in_valid && !in_stall;

  // Decode of the accepted byte against the glyph state it sees.
  always_comb begin
    byte_hi    = in_data_byte[7:4];
    byte_lo    = in_data_byte[3:0];
    lim_sat    = (in_nibble_limit > NRE_LIMIT_CAP) ? NRE_LIMIT_CAP : in_nibble_limit;
    eff_limit  = in_first_of_glyph ? lim_sat : limit_r;
    eff_done   = in_first_of_glyph ? '0 : done_r;
    eff_marker = in_first_of_glyph ? 1'b0 : marker_r;
    active     = (eff_done < eff_limit);
    room       = eff_limit - eff_done;
    want       = eff_marker ? NRE_LIMIT_W'(in_data_byte) : NRE_LIMIT_W'(2);
    total      = (room < want) ? room : want;
    start_emit = accept && active && (eff_marker || (byte_hi != byte_lo)) && (total != '0);
  end

  // Glyph state and work registers.
  always_comb begin
    marker_nxt  = marker_r;
    run_nib_nxt = run_nib_r;
    done_nxt    = done_r;
    limit_nxt   = limit_r;
    rem_nxt     = rem_r;
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    if (accept) begin
      limit_nxt  = eff_limit;
      done_nxt   = eff_done;
      marker_nxt = eff_marker;
      if (active) begin
        if (eff_marker) begin
          marker_nxt = 1'b0;
          hi_nxt     = run_nib_r;
          lo_nxt     = run_nib_r;
        end else if (byte_hi == byte_lo) begin
          marker_nxt  = 1'b1;
          run_nib_nxt = byte_hi;
        end else begin
          hi_nxt = byte_hi;
          lo_nxt = byte_lo;
        end
        rem_nxt = total[NRE_COUNT_W-1:0];
      end
    end else if (load_en) begin
      rem_nxt  = chunk.rem_nxt;
      done_nxt = chunk.done_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      NRE_IDLE: begin
        if (start_emit) begin
          state_nxt = NRE_EMIT;
        end
      end
      NRE_EMIT: begin
        if (load_en && chunk.last) begin
          state_nxt = NRE_IDLE;
        end
      end
      default: state_nxt = NRE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= NRE_IDLE;
      marker_r    <= 1'b0;
      run_nib_r   <= '0;
      done_r      <= '0;
      limit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      marker_r  <= marker_nxt;
      run_nib_r <= run_nib_nxt;
      done_r    <= done_nxt;
      limit_r   <= limit_nxt;
      if (load_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    if (load_en) begin
      out_word_r  <= word;
      out_count_r <= chunk.take;
      out_end_r   <= chunk.last;
      out_limit_r <= chunk.limit_hit;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_nibble_word   = out_word_r;
  assign out_valid_count   = out_count_r;
  assign out_run_end       = out_end_r;
  assign out_limit_reached = out_limit_r;

endmodule

// ----- test/nibble_rle_expander_core_tb.sv -----
// Self-checking testbench for nibble_rle_expander_core: a directed table of glyph bytes,
// then random glyphs, checked against a nibble expansion predictor or, for typed rows, the table.
// Depends on nre_pkg and the design files of the block.
`timescale 1ns / 1ps
module nibble_rle_expander_core_tb;
  import nre_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int BYTE_TARGET  = 450;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 40;
  localparam int PRINT_CAP    = 40;
  localparam int SCRIPT_ROWS  = 24;

  typedef struct packed {
    logic [NRE_WORD_W-1:0] word;
    logic [3:0]            cnt;
    logic                  run_end;
    logic                  lim_hit;
  } word_rec_t;

  typedef struct packed {
    logic [7:0]             b;
    logic                   first;
    logic [NRE_LIMIT_W-1:0] lim;
    logic                   typed;
    word_rec_t              res;
  } script_row_t;

  logic                   clk;
  logic                   rst_n             = 1'b0;
  logic                   in_valid          = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_data_byte      = '0;
  logic                   in_first_of_glyph = 1'b0;
  logic [NRE_LIMIT_W-1:0] in_nibble_limit   = '0;
  logic                   out_valid;
  logic                   out_stall         = 1'b0;
  logic [NRE_WORD_W-1:0]  out_nibble_word;
  logic [3:0]             out_valid_count;
  logic                   out_run_end;
  logic                   out_limit_reached;

  nibble_rle_expander_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_first_of_glyph (in_first_of_glyph),
    .in_nibble_limit   (in_nibble_limit),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_nibble_word   (out_nibble_word),
    .out_valid_count   (out_valid_count),
    .out_run_end       (out_run_end),
    .out_limit_reached (out_limit_reached)
  );

  // Glyph state of the predictor.
  logic                   g_marker;
  logic [3:0]             g_run_nib;
  logic [NRE_LIMIT_W-1:0] g_done;
  logic [NRE_LIMIT_W-1:0] g_limit;

  word_rec_t due_words[$];

  int errors        = 0;
  int cycles        = 0;
  int bytes_used    = 0;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int limit_hits    = 0;
  int glyphs        = 0;
  int runs          = 0;
  int tx_idle_pct   = 28;
  int rx_idle_pct   = 53;

  // Random glyph being built.
  logic                   rnd_first;
  logic [NRE_LIMIT_W-1:0] rnd_limit;

  script_row_t script [SCRIPT_ROWS] = '{
    '{8'h12, 1'b1, 13'd8191, 1'b1, '{32'h12FFFFFF, 4'd2, 1'b1, 1'b0}},
    '{8'hF0, 1'b0, 13'd0,    1'b1, '{32'hF0FFFFFF, 4'd2, 1'b1, 1'b0}},
    '{8'h0F, 1'b0, 13'd0,    1'b1, '{32'h0FFFFFFF, 4'd2, 1'b1, 1'b0}},
    '{8'h77, 1'b0, 13'd0,    1'b0, '0},
    '{8'hFF, 1'b0, 13'd0,    1'b0, '0},
    '{8'h33, 1'b0, 13'd0,    1'b0, '0},
    '{8'h00, 1'b0, 13'd0,    1'b0, '0},
    '{8'hAA, 1'b0, 13'd0,    1'b0, '0},
    '{8'h5A, 1'b1, 13'd3,    1'b1, '{32'h5AFFFFFF, 4'd2, 1'b1, 1'b0}},
    '{8'h11, 1'b0, 13'd0,    1'b0, '0},
    '{8'h05, 1'b0, 13'd0,    1'b1, '{32'h1FFFFFFF, 4'd1, 1'b1, 1'b1}},
    '{8'h9C, 1'b0, 13'd0,    1'b0, '0},
    '{8'hE4, 1'b1, 13'd1,    1'b1, '{32'hEFFFFFFF, 4'd1, 1'b1, 1'b1}},
    '{8'h21, 1'b1, 13'd0,    1'b0, '0},
    '{8'h00, 1'b1, 13'd4096, 1'b0, '0},
    '{8'h08, 1'b0, 13'd0,    1'b1, '{32'h00000000, 4'd8, 1'b1, 1'b0}},
    '{8'hEE, 1'b0, 13'd0,    1'b0, '0},
    '{8'h09, 1'b0, 13'd0,    1'b0, '0},
    '{8'hDD, 1'b1, 13'd16,   1'b0, '0},
    '{8'hFF, 1'b0, 13'd0,    1'b0, '0},
    '{8'h89, 1'b1, 13'd4095, 1'b1, '{32'h89FFFFFF, 4'd2, 1'b1, 1'b0}},
    '{8'hBB, 1'b0, 13'd0,    1'b0, '0},
    '{8'h4C, 1'b1, 13'd5,    1'b0, '0},
    '{8'hC3, 1'b1, 13'd2,    1'b1, '{32'hC3FFFFFF, 4'd2, 1'b1, 1'b1}}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Packs n copies of one nibble, or a high/low pair, into words, stopping at the limit.
  task automatic emit_nibbles(input bit pair, input logic [3:0] hi, input logic [3:0] lo,
                              input int n);
    int        room;
    int        total;
    int        produced;
    int        take;
    logic [3:0] nib;
    word_rec_t r;
    room     = (g_limit > g_done) ? int'(g_limit) - int'(g_done) : 0;
    total    = (n < room) ? n : room;
    produced = 0;
    while (produced < total) begin
      take   = (total - produced < int'(NRE_CHUNK)) ? total - produced : int'(NRE_CHUNK);
      r.word = '0;
      for (int k = 0; k < NRE_NIBS_PER_WORD; k++) begin
        nib = NRE_PAD_NIB;
        if (k < take)
          nib = (pair && produced + k == 1) ? lo : hi;
        r.word = {r.word[NRE_WORD_W-NRE_NIB_W-1:0], nib};
      end
      produced += take;
      g_done    = g_done + NRE_LIMIT_W'(take);
      r.cnt     = 4'(take);
      r.run_end = (produced == total);
      r.lim_hit = (g_done >= g_limit);
      due_words.push_back(r);
    end
  endtask

  // Works out the words that one accepted byte expands into; took is low when ignored.
  task automatic expand_byte(input logic [7:0] b, input logic first,
                             input logic [NRE_LIMIT_W-1:0] lim, output bit took);
    logic [3:0] hi;
    logic [3:0] lo;
    took = 1'b0;
    hi   = b[7:4];
    lo   = b[3:0];
    if (first) begin
      g_marker = 1'b0;
      g_done   = '0;
      g_limit  = (lim > NRE_LIMIT_CAP) ? NRE_LIMIT_CAP : lim;
    end
    if (g_done >= g_limit)
      return;
    took = 1'b1;
    if (g_marker) begin
      g_marker = 1'b0;
      emit_nibbles(1'b0, g_run_nib, g_run_nib, int'(b));
    end else if (hi == lo) begin
      g_marker  = 1'b1;
      g_run_nib = hi;
    end else begin
      emit_nibbles(1'b1, hi, lo, 2);
    end
  endtask

  // Offers one item after a random gap; a typed row replaces the predicted word.
  task automatic send_item(input logic [7:0] b, input logic first,
                           input logic [NRE_LIMIT_W-1:0] lim, input logic typed,
                           input word_rec_t typed_res);
    int before_cnt;
    bit took;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_data_byte      = b;
    in_first_of_glyph = first;
    // The limit is only sampled with a new glyph, so it is scrambled otherwise.
    in_nibble_limit   = first ? lim : NRE_LIMIT_W'($urandom);
    do @(posedge clk); while (in_stall);
    before_cnt = due_words.size();
    expand_byte(b, first, lim, took);
    if (typed) begin
      while (due_words.size() > before_cnt)
        void'(due_words.pop_back());
      due_words.push_back(typed_res);
    end
    bytes_sent++;
    if (took)
      bytes_used++;
    if (first)
      glyphs++;
    @(negedge clk);
  endtask

  task automatic feed_glyph_byte(input logic [7:0] b);
    send_item(b, rnd_first, rnd_limit, 1'b0, '0);
    rnd_first = 1'b0;
  endtask

  task automatic hold_until_drained();
    in_valid = 1'b0;
    while (due_words.size() != 0)
      @(negedge clk);
  endtask

  always @(negedge clk)
    out_stall <= rst_n && ($urandom_range(0, 99) < rx_idle_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    word_rec_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (due_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word %h", out_nibble_word));
      end else begin
        e = due_words.pop_front();
        if (e.lim_hit)
          limit_hits++;
        if (out_nibble_word !== e.word)
          flag_mismatch($sformatf("nibble_word %h, expected %h", out_nibble_word, e.word));
        if (out_valid_count !== e.cnt)
          flag_mismatch($sformatf("valid_count %0d, expected %0d", out_valid_count, e.cnt));
        if (out_run_end !== e.run_end)
          flag_mismatch($sformatf("run_end %b, expected %b", out_run_end, e.run_end));
        if (out_limit_reached !== e.lim_hit)
          flag_mismatch($sformatf("limit_reached %b, expected %b",
                                  out_limit_reached, e.lim_hit));
      end
    end
  end

  initial begin
    int         sel;
    int         drain;
    int         tokens;
    logic [3:0] nib;
    bit         drained_mid;
    g_marker    = 1'b0;
    g_run_nib   = '0;
    g_done      = '0;
    g_limit     = '0;
    rnd_first   = 1'b0;
    rnd_limit   = '0;
    drained_mid = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < SCRIPT_ROWS; i++)
      send_item(script[i].b, script[i].first, script[i].lim, script[i].typed, script[i].res);
    hold_until_drained();

    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent < BYTE_TARGET / 3) begin
        tx_idle_pct = 28;
        rx_idle_pct = 53;
      end else if (bytes_sent < 2 * BYTE_TARGET / 3) begin
        tx_idle_pct = 53;
        rx_idle_pct = 28;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        if (!drained_mid) begin
          hold_until_drained();
          drained_mid = 1'b1;
        end
      end

      sel = $urandom_range(0, 99);
      if (sel < 50)
        rnd_limit = NRE_LIMIT_W'($urandom_range(1, 64));
      else if (sel < 75)
        rnd_limit = NRE_LIMIT_W'($urandom_range(65, 600));
      else if (sel < 85)
        rnd_limit = '0;
      else if (sel < 95)
        rnd_limit = NRE_LIMIT_W'($urandom_range(4000, 8191));
      else
        rnd_limit = NRE_LIMIT_W'($urandom);
      rnd_first = 1'b1;

      tokens = $urandom_range(1, 12);
      repeat (tokens) begin
        sel = $urandom_range(0, 99);
        nib = 4'($urandom);
        if (sel < 55) begin
          feed_glyph_byte({nib, nib ^ 4'($urandom_range(1, 15))});
        end else if (sel < 88) begin
          runs++;
          feed_glyph_byte({nib, nib});
          sel = $urandom_range(0, 99);
          if (sel < 70)
            feed_glyph_byte(8'($urandom_range(1, 20)));
          else if (sel < 90)
            feed_glyph_byte(8'($urandom));
          else
            feed_glyph_byte(8'h00);
        end else if (sel < 94) begin
          // Noise, sometimes cutting into the glyph with a fresh start.
          send_item(8'($urandom), ($urandom_range(0, 3) == 0), NRE_LIMIT_W'($urandom),
                    1'b0, '0);
          rnd_first = 1'b0;
        end else begin
          // A marker whose count byte never comes as intended.
          feed_glyph_byte({nib, nib});
        end
      end
    end
    in_valid = 1'b0;

    drain = 0;
    while (due_words.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_words.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", due_words.size()));

    $display("Run fed %0d bytes (%0d expanded) over %0d glyphs and %0d runs.",
             bytes_sent, bytes_used, glyphs, runs);
    $display("It checked %0d result words, %0d of them at the glyph limit, in %0d cycles.",
             results_seen, limit_hits, cycles);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
